### hdl/ecp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp_pkg: shared types and constants for the two-point conductivity block
// Formats: volts Q3.16, temperature Q8.8, coefficient Q0.16, factors Q.16.
// ----------------------------------------------------------------------------
package ecp_pkg;

  localparam int VOLT_W   = 19;
  localparam int AEC_W    = 18;
  localparam int TEMP_W   = 16;
  localparam int COEF_W   = 13;
  localparam int SLOPE_W  = 32;
  localparam int OFFS_W   = 18;
  localparam int CFG_W    = 32;
  localparam int CFG_A_W  = 3;

  localparam int EC_OUT_W = 20;
  localparam int NEAT_W   = 24;
  localparam int SG_W     = 19;

  localparam int REFERENCE_TEMP   = 6400;
  localparam int PPM_FACTOR_Q8    = 128;
  localparam int DILUTION_Q8      = 256;
  localparam int ONE_Q16          = 65536;
  localparam int FACTOR_FLOOR_Q16 = 6554;
  localparam int FAULT_LIMIT_LSB  = 6;

  localparam int K_W    = 20;   // temperature factor, Q.16 unsigned
  localparam int PK_W   = 31;   // coefficient times temperature difference
  localparam int MAG_W  = 39;   // magnitude of the line numerator
  localparam int N_W    = MAG_W + K_W;
  localparam int D_W    = VOLT_W + K_W;
  localparam int DEN_W  = D_W + 1;
  localparam int DIV_W  = N_W + 2;
  localparam int Q_W    = EC_OUT_W;

  localparam logic [EC_OUT_W-1:0] EC_MAX   = '1;
  localparam logic [NEAT_W-1:0]   NEAT_MAX = '1;

  typedef enum logic [CFG_A_W-1:0] {
    REG_LOW_V    = 3'd0,
    REG_HIGH_V   = 3'd1,
    REG_LOW_EC   = 3'd2,
    REG_HIGH_EC  = 3'd3,
    REG_CAL_TEMP = 3'd4,
    REG_TEMP_CO  = 3'd5,
    REG_SG_SLOPE = 3'd6,
    REG_SG_OFFS  = 3'd7
  } cfg_addr_t;

  typedef struct packed {
    logic [VOLT_W-1:0]        low_v;
    logic [VOLT_W-1:0]        high_v;
    logic [AEC_W-1:0]         low_ec;
    logic [AEC_W-1:0]         high_ec;
    logic signed [TEMP_W-1:0] cal_temp;
    logic [COEF_W-1:0]        temp_co;
    logic signed [SLOPE_W-1:0] sg_slope;
    logic [OFFS_W-1:0]        sg_offs;
  } cfg_t;

  // per-item side flags carried alongside the datapath
  typedef struct packed {
    logic fault;   // anchor voltages too close
    logic pos;     // line value above zero
  } flags_t;

  // 1 + coef*dT, rounded from Q.24 to Q.16, floored at 0.1
  function automatic logic [K_W-1:0] k_factor(input logic signed [PK_W-1:0] p);
    logic signed [PK_W-1:0] s;
    logic signed [23:0] k;
    s = (p + PK_W'(128)) >>> 8;
    k = 24'(s) + 24'sd65536;
    if (k < 24'sd6554) k = 24'sd6554;
    return k[K_W-1:0];
  endfunction

endpackage

### hdl/ecp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp_front: temperature factors, line numerator, scaled dividend and divisor
// Five register stages; advances when en is high.
// ----------------------------------------------------------------------------
module ecp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [ecp_pkg::VOLT_W-1:0]        sample_voltage,
  input  logic signed [ecp_pkg::TEMP_W-1:0] sample_temp,
  input  ecp_pkg::cfg_t                     cfg,
  output logic                              out_valid,
  output logic [ecp_pkg::DIV_W-1:0]         out_rem,
  output logic [ecp_pkg::DEN_W-1:0]         out_den,
  output logic                              out_sat,
  output ecp_pkg::flags_t                   out_flags
);

  // stage A
  logic                              a_valid_r;
  logic signed [ecp_pkg::VOLT_W:0]   a_dv_r, a_dvl_r;
  logic signed [ecp_pkg::AEC_W:0]    a_dec_r;
  logic signed [ecp_pkg::PK_W-1:0]   a_pks_r, a_pkc_r;
  logic                              a_fault_r;
  logic signed [ecp_pkg::VOLT_W:0]   a_dv_nxt;
  logic signed [ecp_pkg::TEMP_W:0]   a_tds, a_tdc;

  always_comb begin
    a_dv_nxt = $signed({1'b0, cfg.high_v}) - $signed({1'b0, cfg.low_v});
    a_tds = $signed({sample_temp[ecp_pkg::TEMP_W-1], sample_temp})
            - (ecp_pkg::TEMP_W+1)'(ecp_pkg::REFERENCE_TEMP);
    a_tdc = $signed({cfg.cal_temp[ecp_pkg::TEMP_W-1], cfg.cal_temp})
            - (ecp_pkg::TEMP_W+1)'(ecp_pkg::REFERENCE_TEMP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dv_r    <= a_dv_nxt;
      a_dvl_r   <= $signed({1'b0, sample_voltage}) - $signed({1'b0, cfg.low_v});
      a_dec_r   <= $signed({1'b0, cfg.high_ec}) - $signed({1'b0, cfg.low_ec});
      a_pks_r   <= $signed({1'b0, cfg.temp_co}) * a_tds;
      a_pkc_r   <= $signed({1'b0, cfg.temp_co}) * a_tdc;
      a_fault_r <= (a_dv_nxt <= (ecp_pkg::VOLT_W+1)'(ecp_pkg::FAULT_LIMIT_LSB)) &&
                   (a_dv_nxt >= -(ecp_pkg::VOLT_W+1)'(ecp_pkg::FAULT_LIMIT_LSB));
    end
  end

  // stage B
  logic                              b_valid_r;
  logic signed [ecp_pkg::MAG_W-1:0]  b_p1_r, b_p2_r;
  logic [ecp_pkg::K_W-1:0]           b_ks_r, b_kc_r;
  logic                              b_neg_r, b_fault_r;
  logic [ecp_pkg::VOLT_W-1:0]        b_dvabs_r;
  logic signed [ecp_pkg::VOLT_W:0]   b_dvabs_nxt;

  assign b_dvabs_nxt = a_dv_r[ecp_pkg::VOLT_W] ? -a_dv_r : a_dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_p1_r    <= $signed({1'b0, cfg.low_ec}) * a_dv_r;
      b_p2_r    <= a_dec_r * a_dvl_r;
      b_ks_r    <= ecp_pkg::k_factor(a_pks_r);
      b_kc_r    <= ecp_pkg::k_factor(a_pkc_r);
      b_neg_r   <= a_dv_r[ecp_pkg::VOLT_W];
      b_dvabs_r <= b_dvabs_nxt[ecp_pkg::VOLT_W-1:0];
      b_fault_r <= a_fault_r;
    end
  end

  // stage C: numerator sum, sign folded so the divisor is positive
  logic                              c_valid_r;
  logic [ecp_pkg::MAG_W-1:0]         c_mag_r;
  logic [ecp_pkg::K_W-1:0]           c_ks_r, c_kc_r;
  logic [ecp_pkg::VOLT_W-1:0]        c_dvabs_r;
  ecp_pkg::flags_t                   c_flags_r;
  logic signed [ecp_pkg::MAG_W+1:0]  c_sum, c_adj;

  always_comb begin
    c_sum = (ecp_pkg::MAG_W+2)'(b_p1_r) + (ecp_pkg::MAG_W+2)'(b_p2_r);
    c_adj = b_neg_r ? -c_sum : c_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mag_r         <= c_adj[ecp_pkg::MAG_W-1:0];
      c_ks_r          <= b_ks_r;
      c_kc_r          <= b_kc_r;
      c_dvabs_r       <= b_dvabs_r;
      c_flags_r.fault <= b_fault_r;
      c_flags_r.pos   <= (c_adj > 0);
    end
  end

  // stage D: n = num*kc, d = |dV|*ks
  logic                              d_valid_r;
  logic [ecp_pkg::N_W-1:0]           d_n_r;
  logic [ecp_pkg::D_W-1:0]           d_d_r;
  ecp_pkg::flags_t                   d_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_n_r     <= ecp_pkg::N_W'(c_mag_r) * ecp_pkg::N_W'(c_kc_r);
      d_d_r     <= ecp_pkg::D_W'(c_dvabs_r) * ecp_pkg::D_W'(c_ks_r);
      d_flags_r <= c_flags_r;
    end
  end

  // stage E: round-to-nearest as floor((2n+d)/(2d)), overflow check
  logic                              e_valid_r;
  logic [ecp_pkg::DIV_W-1:0]         e_num;
  logic [ecp_pkg::DEN_W-1:0]         e_den;

  always_comb begin
    e_num = (ecp_pkg::DIV_W'(d_n_r) << 1) + ecp_pkg::DIV_W'(d_d_r);
    e_den = {d_d_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem   <= e_num;
      out_den   <= e_den;
      out_sat   <= (e_num >= (ecp_pkg::DIV_W'(e_den) << ecp_pkg::Q_W));
      out_flags <= d_flags_r;
    end
  end

  assign out_valid = e_valid_r;

endmodule

### hdl/ecp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp_div: pipelined restoring divider, one quotient bit per stage
// The dividend is below den << Q_W unless the sat flag is set.
// ----------------------------------------------------------------------------
module ecp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ecp_pkg::DIV_W-1:0] in_rem,
  input  logic [ecp_pkg::DEN_W-1:0] in_den,
  input  logic                      in_sat,
  input  ecp_pkg::flags_t           in_flags,
  output logic                      out_valid,
  output logic [ecp_pkg::Q_W-1:0]   out_quot,
  output logic                      out_sat,
  output ecp_pkg::flags_t           out_flags
);

  localparam int NS = ecp_pkg::Q_W;

  logic                      v_r   [NS];
  logic [ecp_pkg::DIV_W-1:0] rem_r [NS];
  logic [ecp_pkg::DEN_W-1:0] den_r [NS];
  logic [ecp_pkg::Q_W-1:0]   q_r   [NS];
  logic                      sat_r [NS];
  ecp_pkg::flags_t           flg_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int SH = NS - 1 - s;
    logic                      v_in;
    logic [ecp_pkg::DIV_W-1:0] rem_in, trial;
    logic [ecp_pkg::DEN_W-1:0] den_in;
    logic [ecp_pkg::Q_W-1:0]   q_in;
    logic                      sat_in;
    ecp_pkg::flags_t           flg_in;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_rem;
      assign den_in = in_den;
      assign q_in   = '0;
      assign sat_in = in_sat;
      assign flg_in = in_flags;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
      assign sat_in = sat_r[s-1];
      assign flg_in = flg_r[s-1];
    end

    assign trial = ecp_pkg::DIV_W'(den_in) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_in;
        sat_r[s] <= sat_in;
        flg_r[s] <= flg_in;
        if (rem_in >= trial) begin
          rem_r[s] <= rem_in - trial;
          q_r[s]   <= q_in | (ecp_pkg::Q_W'(1) << SH);
        end else begin
          rem_r[s] <= rem_in;
          q_r[s]   <= q_in;
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_quot  = q_r[NS-1];
  assign out_sat   = sat_r[NS-1];
  assign out_flags = flg_r[NS-1];

endmodule

### hdl/ecp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp_back: EC selection, ppm and dilution scaling, specific gravity
// Three register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module ecp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [ecp_pkg::Q_W-1:0]             in_quot,
  input  logic                                in_sat,
  input  ecp_pkg::flags_t                     in_flags,
  input  logic signed [ecp_pkg::SLOPE_W-1:0]  sg_slope,
  input  logic [ecp_pkg::OFFS_W-1:0]          sg_offs,
  output logic                                out_valid,
  output logic [ecp_pkg::EC_OUT_W-1:0]        ec_reference,
  output logic [ecp_pkg::EC_OUT_W-1:0]        tds_ppm,
  output logic [ecp_pkg::NEAT_W-1:0]          ec_neat_sample,
  output logic signed [ecp_pkg::SG_W-1:0]     specific_gravity,
  output logic                                calibration_fault
);

  localparam int TP_W = ecp_pkg::EC_OUT_W + 10;
  localparam int NP_W = ecp_pkg::EC_OUT_W + 16;
  localparam int PR_W = ecp_pkg::SLOPE_W + ecp_pkg::NEAT_W + 1;

  // stage F
  logic                           f_valid_r, f_fault_r;
  logic [ecp_pkg::EC_OUT_W-1:0]   f_ec_r, f_tds_r;
  logic [ecp_pkg::NEAT_W-1:0]     f_neat_r;
  logic [ecp_pkg::EC_OUT_W-1:0]   f_ec;
  logic [TP_W-1:0]                f_tp;
  logic [NP_W-1:0]                f_np;

  always_comb begin
    if (in_flags.fault || !in_flags.pos) f_ec = '0;
    else if (in_sat)                     f_ec = ecp_pkg::EC_MAX;
    else                                 f_ec = in_quot;
    f_tp = (TP_W'(f_ec) * TP_W'(ecp_pkg::PPM_FACTOR_Q8) + TP_W'(128)) >> 8;
    f_np = (NP_W'(f_ec) * NP_W'(ecp_pkg::DILUTION_Q8) + NP_W'(128)) >> 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_fault_r <= in_flags.fault;
      f_ec_r    <= f_ec;
      f_tds_r   <= (f_tp > TP_W'(ecp_pkg::EC_MAX)) ? ecp_pkg::EC_MAX
                                                  : f_tp[ecp_pkg::EC_OUT_W-1:0];
      f_neat_r  <= (f_np > NP_W'(ecp_pkg::NEAT_MAX)) ? ecp_pkg::NEAT_MAX
                                                   : f_np[ecp_pkg::NEAT_W-1:0];
    end
  end

  // stage G: slope times neat EC
  logic                           g_valid_r, g_fault_r;
  logic [ecp_pkg::EC_OUT_W-1:0]   g_ec_r, g_tds_r;
  logic [ecp_pkg::NEAT_W-1:0]     g_neat_r;
  logic signed [PR_W-1:0]         g_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (en) begin
      g_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_fault_r <= f_fault_r;
      g_ec_r    <= f_ec_r;
      g_tds_r   <= f_tds_r;
      g_neat_r  <= f_neat_r;
      g_prod_r  <= sg_slope * $signed({1'b0, f_neat_r});
    end
  end

  // stage H: round, add offset, saturate; zero on fault
  logic signed [PR_W-1:0] h_rs;
  logic signed [PR_W:0]   h_sg;
  logic                   h_valid_r;

  always_comb begin
    h_rs = (g_prod_r + PR_W'(1 << 23)) >>> 24;
    h_sg = $signed({1'b0, (PR_W)'(sg_offs)}) + (PR_W+1)'(h_rs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
    end else if (en) begin
      h_valid_r <= g_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      calibration_fault <= g_fault_r;
      ec_reference      <= g_ec_r;
      tds_ppm           <= g_tds_r;
      ec_neat_sample    <= g_neat_r;
      if (g_fault_r)                                specific_gravity <= '0;
      else if (h_sg > (PR_W+1)'(262143))            specific_gravity <= 19'sd262143;
      else if (h_sg < -(PR_W+1)'(262144))           specific_gravity <= -19'sd262144;
      else specific_gravity <= h_sg[ecp_pkg::SG_W-1:0];
    end
  end

  assign out_valid = h_valid_r;

endmodule

### hdl/two_point_conductivity_with_temp_comp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_point_conductivity_with_temp_comp: temperature compensated EC meter
// Two-point line fit, temperature normalization, ppm, dilution and SG.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  channel: one item per sample (voltage Q3.16, temperature Q8.8).
//  out_* channel: one result item per input item, in order.
//  cfg_* port: write-only register file, to be written while the block is idle; the block does not enforce this.
//  The pipeline has 5 front stages (factors, products, dividend),
//  20 divider stages (one quotient bit each) and 3 back stages.
//  Throughput is one item per cycle while the receiver does not stall.
//  Reset clears every valid bit and loads the register defaults.
//  When the receiver stalls, the whole pipeline holds and in_tready drops;
//  nothing is lost or repeated. A held result stays on out_tdata.
//  Faulted items (anchor voltages within 6 LSB) give all-zero data and
//  out_tuser set.
// ----------------------------------------------------------------------------
module two_point_conductivity_with_temp_comp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,   // sample_voltage, sample_temp
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // ec_reference, tds_ppm, ec_neat_sample, specific_gravity
  output logic [87:0]                  out_tdata,
  output logic                         out_tuser,  // calibration_fault
  input  logic                         cfg_wr_en,
  input  logic [ecp_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [ecp_pkg::CFG_W-1:0]    cfg_wdata
);

  ecp_pkg::cfg_t cfg_r;
  logic          en;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_v    <= '0;
      cfg_r.high_v   <= 19'd327680;
      cfg_r.low_ec   <= 18'd1413;
      cfg_r.high_ec  <= 18'd12880;
      cfg_r.cal_temp <= 16'sd6400;
      cfg_r.temp_co  <= 13'd1311;
      cfg_r.sg_slope <= '0;
      cfg_r.sg_offs  <= 18'd65536;
    end else if (cfg_wr_en) begin
      unique case (ecp_pkg::cfg_addr_t'(cfg_addr))
        ecp_pkg::REG_LOW_V:    cfg_r.low_v    <= cfg_wdata[ecp_pkg::VOLT_W-1:0];
        ecp_pkg::REG_HIGH_V:   cfg_r.high_v   <= cfg_wdata[ecp_pkg::VOLT_W-1:0];
        ecp_pkg::REG_LOW_EC:   cfg_r.low_ec   <= cfg_wdata[ecp_pkg::AEC_W-1:0];
        ecp_pkg::REG_HIGH_EC:  cfg_r.high_ec  <= cfg_wdata[ecp_pkg::AEC_W-1:0];
        ecp_pkg::REG_CAL_TEMP: cfg_r.cal_temp <= cfg_wdata[ecp_pkg::TEMP_W-1:0];
        ecp_pkg::REG_TEMP_CO:  cfg_r.temp_co  <= cfg_wdata[ecp_pkg::COEF_W-1:0];
        ecp_pkg::REG_SG_SLOPE: cfg_r.sg_slope <= cfg_wdata[ecp_pkg::SLOPE_W-1:0];
        ecp_pkg::REG_SG_OFFS:  cfg_r.sg_offs  <= cfg_wdata[ecp_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  logic                          fr_valid, fr_sat;
  logic [ecp_pkg::DIV_W-1:0]     fr_rem;
  logic [ecp_pkg::DEN_W-1:0]     fr_den;
  ecp_pkg::flags_t               fr_flags;

  ecp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_tvalid),
    .sample_voltage (in_tdata[18:0]),
    .sample_temp    (in_tdata[34:19]),
    .cfg            (cfg_r),
    .out_valid      (fr_valid),
    .out_rem        (fr_rem),
    .out_den        (fr_den),
    .out_sat        (fr_sat),
    .out_flags      (fr_flags)
  );

  logic                          dv_valid, dv_sat;
  logic [ecp_pkg::Q_W-1:0]       dv_quot;
  ecp_pkg::flags_t               dv_flags;

  ecp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_rem    (fr_rem),
    .in_den    (fr_den),
    .in_sat    (fr_sat),
    .in_flags  (fr_flags),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_sat   (dv_sat),
    .out_flags (dv_flags)
  );

  logic [ecp_pkg::EC_OUT_W-1:0]   ec_reference, tds_ppm;
  logic [ecp_pkg::NEAT_W-1:0]     ec_neat_sample;
  logic signed [ecp_pkg::SG_W-1:0] specific_gravity;

  ecp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .in_valid          (dv_valid),
    .in_quot           (dv_quot),
    .in_sat            (dv_sat),
    .in_flags          (dv_flags),
    .sg_slope          (cfg_r.sg_slope),
    .sg_offs           (cfg_r.sg_offs),
    .out_valid         (out_tvalid),
    .ec_reference      (ec_reference),
    .tds_ppm           (tds_ppm),
    .ec_neat_sample    (ec_neat_sample),
    .specific_gravity  (specific_gravity),
    .calibration_fault (out_tuser)
  );

  assign out_tdata = {5'd0, specific_gravity, ec_neat_sample, tds_ppm, ec_reference};

`ifndef SYNTHESIS
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("faulted item carries nonzero data");

  a_neat_ge_ec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ec_neat_sample >= ecp_pkg::NEAT_W'(ec_reference))
    else $error("neat EC below reference EC");

  a_zero_tds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ec_reference == '0 |-> tds_ppm == '0 && ec_neat_sample == '0)
    else $error("zero EC with nonzero derived values");
`endif

endmodule

### tb/two_point_conductivity_with_temp_comp_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_point_conductivity_with_temp_comp_test: self-checking bench
// Drives random and corner samples through several register settings and
// handshake patterns. Each result is compared with an in-bench calculation.
// ----------------------------------------------------------------------------

typedef struct {
  logic [19:0] ec;
  logic [19:0] tds;
  logic [23:0] neat;
  logic [18:0] sg;
  logic        fault;
} ec_result_t;

class ec_scoreboard;
  ec_result_t pending[$];
  int         errors;
  longint     low_v, high_v, low_ec, high_ec, cal_t, coef, slope, offs;

  function new();
    errors  = 0;
    low_v   = 0;
    high_v  = 327680;
    low_ec  = 1413;
    high_ec = 12880;
    cal_t   = 6400;
    coef    = 1311;
    slope   = 0;
    offs    = 65536;
  endfunction

  function void set_reg(ecp_pkg::cfg_addr_t a, logic [31:0] d);
    case (a)
      ecp_pkg::REG_LOW_V:    low_v   = d[18:0];
      ecp_pkg::REG_HIGH_V:   high_v  = d[18:0];
      ecp_pkg::REG_LOW_EC:   low_ec  = d[17:0];
      ecp_pkg::REG_HIGH_EC:  high_ec = d[17:0];
      ecp_pkg::REG_CAL_TEMP: cal_t   = $signed(d[15:0]);
      ecp_pkg::REG_TEMP_CO:  coef    = d[12:0];
      ecp_pkg::REG_SG_SLOPE: slope   = $signed(d);
      ecp_pkg::REG_SG_OFFS:  offs    = d[17:0];
      default: ;
    endcase
  endfunction

  function longint temp_factor(longint t);
    longint d, k;
    d = coef * (t - ecp_pkg::REFERENCE_TEMP);
    k = ecp_pkg::ONE_Q16 + ((d + 128) >>> 8);
    return (k < ecp_pkg::FACTOR_FLOOR_Q16) ? ecp_pkg::FACTOR_FLOOR_Q16 : k;
  endfunction

  function void note_input(logic [18:0] v_in, logic [15:0] t_in);
    ec_result_t r;
    longint dv, num, kc, ks, sg, v, t;
    longint unsigned n, dd, ec, tds, neat;
    v  = v_in;
    t  = $signed(t_in);
    dv = high_v - low_v;
    r  = '{default: 0};
    if (dv <= ecp_pkg::FAULT_LIMIT_LSB && dv >= -ecp_pkg::FAULT_LIMIT_LSB) begin
      r.fault = 1'b1;
      pending.push_back(r);
      return;
    end
    kc  = temp_factor(cal_t);
    ks  = temp_factor(t);
    num = low_ec * dv + (high_ec - low_ec) * (v - low_v);
    if (dv < 0) begin
      dv  = -dv;
      num = -num;
    end
    ec = 0;
    if (num > 0) begin
      n  = longint'(num) * longint'(kc);
      dd = longint'(dv) * longint'(ks);
      ec = (2 * n + dd) / (2 * dd);
      if (ec > 1048575) ec = 1048575;
    end
    tds = (ec * ecp_pkg::PPM_FACTOR_Q8 + 128) >> 8;
    if (tds > 1048575) tds = 1048575;
    neat = (ec * ecp_pkg::DILUTION_Q8 + 128) >> 8;
    if (neat > 16777215) neat = 16777215;
    sg = offs + ((slope * longint'(neat) + (longint'(1) << 23)) >>> 24);
    if (sg > 262143) sg = 262143;
    if (sg < -262144) sg = -262144;
    r.ec   = ec[19:0];
    r.tds  = tds[19:0];
    r.neat = neat[23:0];
    r.sg   = sg[18:0];
    pending.push_back(r);
  endfunction

  function void check_result(logic [87:0] data, logic flag);
    ec_result_t e;
    if (pending.size() == 0) begin
      $error("result item with nothing expected: data %h", data);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (data[19:0] !== e.ec) begin
      $error("ec_reference: expected %0d, got %0d", e.ec, data[19:0]);
      errors++;
    end
    if (data[39:20] !== e.tds) begin
      $error("tds_ppm: expected %0d, got %0d", e.tds, data[39:20]);
      errors++;
    end
    if (data[63:40] !== e.neat) begin
      $error("ec_neat_sample: expected %0d, got %0d", e.neat, data[63:40]);
      errors++;
    end
    if (data[82:64] !== e.sg) begin
      $error("specific_gravity: expected %0d, got %0d",
             $signed(e.sg), $signed(data[82:64]));
      errors++;
    end
    if (flag !== e.fault) begin
      $error("calibration_fault: expected %0d, got %0d", e.fault, flag);
      errors++;
    end
  endfunction
endclass

module two_point_conductivity_with_temp_comp_test;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // sample_voltage, sample_temp
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;   // ec_reference, tds_ppm, ec_neat_sample, specific_gravity
  logic        out_tuser;   // calibration_fault
  logic        cfg_wr_en;
  logic [ecp_pkg::CFG_A_W-1:0] cfg_addr;
  logic [ecp_pkg::CFG_W-1:0]   cfg_wdata;

  ec_scoreboard sb;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_off_req;
  int     hold_off_cnt;
  longint cycles;

  localparam longint CYCLE_LIMIT = 600000;

  two_point_conductivity_with_temp_comp dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off_req > 0) begin
      hold_off_cnt <= hold_off_req;
      hold_off_req = 0;
      out_tready <= 1'b0;
    end else if (hold_off_cnt > 0) begin
      hold_off_cnt <= hold_off_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata[18:0], in_tdata[34:19]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(ecp_pkg::cfg_addr_t a, logic [31:0] d);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    sb.set_reg(a, d);
    @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] lv, logic [31:0] hv, logic [31:0] lec,
                             logic [31:0] hec, logic [31:0] ct, logic [31:0] co,
                             logic [31:0] sl, logic [31:0] of);
    write_reg(ecp_pkg::REG_LOW_V, lv);
    write_reg(ecp_pkg::REG_HIGH_V, hv);
    write_reg(ecp_pkg::REG_LOW_EC, lec);
    write_reg(ecp_pkg::REG_HIGH_EC, hec);
    write_reg(ecp_pkg::REG_CAL_TEMP, ct);
    write_reg(ecp_pkg::REG_TEMP_CO, co);
    write_reg(ecp_pkg::REG_SG_SLOPE, sl);
    write_reg(ecp_pkg::REG_SG_OFFS, of);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_sample(logic [18:0] v, logic [15:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, t, v};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [18:0] rand_voltage();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 19'($urandom_range(327680));
    if (sel < 80) return 19'($urandom);
    // near the low anchor voltage
    return 19'(sb.low_v + $urandom_range(200) - 100);
  endfunction

  function automatic logic [15:0] rand_temp();
    if ($urandom_range(99) < 70) return 16'($urandom_range(35840) - 10240);
    return 16'($urandom);
  endfunction

  initial begin
    int p;
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_wr_en = 0; cfg_addr = '0; cfg_wdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off_req = 0; hold_off_cnt = 0;
    cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners with reset settings: field extremes and factor floor
    send_sample(19'd0, 16'd6400);
    send_sample(19'd327680, 16'd6400);
    send_sample(19'h7FFFF, 16'h8000);
    send_sample(19'd163840, 16'h7FFF);
    send_sample(19'd163840, 16'($signed(-10240)));
    send_sample(19'd163840, 16'd25600);
    send_sample(19'd100, 16'h8000);
    send_sample(19'h55555, 16'h5555);
    send_sample(19'h2AAAA, 16'hAAAA);
    drain();
    // reversed anchors, value at the line's zero
    load_config(327680, 0, 200000, 0, 25600, 6553, 32'h7FFFFFFF, 262143);
    send_sample(19'd0, 16'd6400);
    send_sample(19'd327680, 16'h8000);
    send_sample(19'h7FFFF, 16'd0);
    send_sample(19'd1000, 16'h7FFF);
    drain();
    // near-degenerate anchors: faulted at 6 LSB, working at 7
    load_config(1000, 1006, 0, 200000, 16'h8000, 0, 32'h80000000, 0);
    send_sample(19'd1000, 16'd0);
    send_sample(19'h7FFFF, 16'h7FFF);
    drain();
    load_config(1007, 1000, 0, 200000, 16'h8000, 0, 32'h80000000, 0);
    send_sample(19'd0, 16'd0);
    send_sample(19'h7FFFF, 16'h7FFF);
    send_sample(19'd1003, 16'd6400);
    drain();

    for (p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      case (p)
        0: load_config(0, 327680, 200000, 200000, 25600, 6553, 32'h7FFFFFFF, 262143);
        1: load_config(327680, 0, 0, 0, 16'($signed(-10240)), 0, 32'h80000000, 0);
        2: load_config(500, 505, 1413, 12880, 6400, 1311, 0, 65536);
        3: load_config(0, 327680, 1413, 12880, 6400, 1311, 0, 65536);
        default: begin
          if ($urandom_range(3) == 0)
            load_config($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
          else
            load_config($urandom_range(327680), $urandom_range(327680),
                        $urandom_range(200000), $urandom_range(200000),
                        $urandom_range(35840) - 10240, $urandom_range(6553),
                        $urandom, $urandom_range(262143));
        end
      endcase
      // keep the output blocked so the pipeline fills and backs up
      if (p == 4) hold_off_req = 300;
      repeat (100) send_sample(rand_voltage(), rand_temp());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
